FILE: rtl/law_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// law_pkg
// Shared types and constants for the lattice aggregation walker.
// ----------------------------------------------------------------------------
package law_pkg;

    localparam int GRID_SIZE = 128;
    localparam int HALF      = GRID_SIZE / 2;
    localparam int CW        = $clog2(GRID_SIZE);
    localparam int AW        = 2 * CW;
    localparam int CELLS     = GRID_SIZE * GRID_SIZE;

    localparam logic       OP_LAUNCH = 1'b0;
    localparam logic       OP_STEP   = 1'b1;
    localparam logic [1:0] DIR_PX    = 2'd0;
    localparam logic [1:0] DIR_MX    = 2'd1;
    localparam logic [1:0] DIR_PY    = 2'd2;
    localparam logic [1:0] DIR_MY    = 2'd3;

    localparam logic [0:0] REG_LAUNCH = 1'b0;
    localparam logic [0:0] REG_KILL   = 1'b1;

    typedef struct packed {
        logic               op;
        logic [1:0]         dir;
        logic signed [15:0] cos_q;
        logic signed [15:0] sin_q;
    } t_req;

    typedef struct packed {
        logic [6:0]  pos_x;
        logic [6:0]  pos_y;
        logic        stuck;
        logic        walking;
        logic [14:0] particles;
        logic [15:0] radius_q;
        logic        done_res;
    } t_rsp;

endpackage

FILE: rtl/law_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// law_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module law_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: rtl/law_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// law_sqrt
// Bit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module law_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [33:0] i_val,
    output logic        o_done,
    output logic [16:0] o_root
);
    logic [33:0] r_rem, n_rem;
    logic [16:0] r_root, n_root;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [35:0] w_trial;
    logic [35:0] w_remx;

    always_comb begin
        n_rem  = r_rem;
        n_root = r_root;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        w_remx = {r_rem, 2'b00};
        w_trial = {17'd0, r_root, 2'b01};
        if (i_start) begin
            n_rem  = i_val;
            n_root = '0;
            n_cnt  = 5'd17;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if ({2'b00, r_rem} >= (w_trial << (2 * (r_cnt - 5'd1)))) begin
                n_rem  = r_rem - 34'((w_trial << (2 * (r_cnt - 5'd1))));
                n_root = {r_root[15:0], 1'b1};
            end else begin
                n_root = {r_root[15:0], 1'b0};
            end
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_busy && (r_cnt == 5'd1);
    assign o_root = {r_root[15:0], ({2'b00, r_rem} >= (w_trial)) ? 1'b1 : 1'b0};
endmodule

FILE: rtl/lattice_aggregation_walker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lattice_aggregation_walker_core
// Diffusion-limited aggregation walker on an occupancy grid in block RAM.
//
// Requests enter on i_req_valid/o_req_ready and carry a launch or a step.
// Every request yields one response on o_rsp_valid/i_rsp_ready holding the
// walker cell, stick and activity flags, particle count and cluster radius.
// A launch passes through the multiply, cell, square, activity and own-cell
// states before it answers. A step moves the walker, then reads the four
// neighbour cells one at a time from the single-port occupancy RAM and then
// its own cell. A sticking step writes its cell and, when the radius grows,
// also runs the bit-serial square root. A step on an inactive walker goes
// straight to the output state without moving. One request is in work at a
// time. After reset the occupancy RAM is cleared by a pass over all
// GRID_SIZE*GRID_SIZE cells (16384 at 128) that also seeds the centre cell;
// no request is taken during it. A stalled response sits in an output register
// while the next request is already being processed; a new result waits for
// that register to empty. Margins are set over APB at addresses 0 and 4.
// ----------------------------------------------------------------------------
module lattice_aggregation_walker_core
    import law_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  t_req        i_req,
    output logic        o_rsp_valid,
    input  logic        i_rsp_ready,
    output t_rsp        o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    typedef enum logic [11:0] {
        S_CLR   = 12'b000000000001,
        S_IDLE  = 12'b000000000010,
        S_MUL   = 12'b000000000100,
        S_CELL  = 12'b000000001000,
        S_SQ    = 12'b000000010000,
        S_RD    = 12'b000000100000,
        S_NB    = 12'b000001000000,
        S_STK   = 12'b000010000000,
        S_SQRT  = 12'b000100000000,
        S_ACT   = 12'b001000000000,
        S_OWN   = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } t_state;

    t_state r_st, n_st;
    logic [5:0]  r_lm;
    logic [6:0]  r_km;
    logic signed [8:0] r_ox, n_ox, r_oy, n_oy;
    logic [CW-1:0] r_cx, n_cx, r_cy, n_cy;
    logic [15:0] r_rm, n_rm;
    logic [14:0] r_pc, n_pc;
    logic r_act, n_act, r_stk, n_stk, r_nb, n_nb, r_op, n_op;
    logic signed [15:0] r_cos, n_cos, r_sin, n_sin;
    logic [AW:0] r_clr, n_clr;
    logic [2:0] r_k, n_k;
    logic [33:0] r_r2, n_r2;
    logic r_kill, n_kill, r_grow, n_grow;
    logic r_ov, n_ov;
    t_rsp r_rsp, n_rsp;

    logic        m_we, m_wd, m_rd;
    logic [AW-1:0] m_a;
    logic sq_start, sq_done;
    logic [16:0] sq_root;

    law_ram #(.WIDTH(1), .DEPTH(CELLS)) u_occ (
        .i_clk(i_clk), .i_we(m_we), .i_addr(m_a), .i_wdata(m_wd), .o_rdata(m_rd)
    );
    law_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sq_start), .i_val(r_r2),
        .o_done(sq_done), .o_root(sq_root)
    );

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_KILL) ? {25'd0, r_km} : {26'd0, r_lm};
    assign o_req_ready = (r_st == S_IDLE);
    assign o_rsp_valid = r_ov;
    assign o_rsp = r_rsp;

    // Launch products: 17-bit unsigned radius times 16-bit signed direction.
    logic [16:0] w_rn;
    logic signed [33:0] w_px, w_py;
    logic [33:0] w_mx, w_my;
    logic [17:0] w_kr;
    logic [35:0] w_kr2;
    logic w_in;
    logic [CW-1:0] w_nx, w_ny;

    function automatic logic signed [8:0] sat9(input logic signed [33:0] v);
        if (v < -34'sd256) return -9'sd256;
        else if (v > 34'sd255) return 9'sd255;
        else return v[8:0];
    endfunction

    always_comb begin
        w_rn = {1'b0, r_rm} + {3'd0, r_lm, 8'd0};
        w_px = $signed({1'b0, w_rn}) * r_cos;
        w_py = $signed({1'b0, w_rn}) * r_sin;
        w_mx = w_px[33] ? 34'(-w_px) : w_px;
        w_my = w_py[33] ? 34'(-w_py) : w_py;
        w_kr = {2'b00, r_rm} + {3'd0, r_km, 8'd0};
        w_kr2 = w_kr * w_kr;
        w_in = (r_ox > -9'sd64) && (r_ox < 9'sd63) && (r_oy > -9'sd64) && (r_oy < 9'sd63);
        w_nx = CW'(r_ox + 9'sd64);
        w_ny = CW'(r_oy + 9'sd64);
    end

    always_comb begin
        n_st = r_st;
        n_ox = r_ox; n_oy = r_oy; n_cx = r_cx; n_cy = r_cy;
        n_rm = r_rm; n_pc = r_pc; n_act = r_act; n_stk = r_stk; n_nb = r_nb;
        n_op = r_op; n_cos = r_cos; n_sin = r_sin; n_clr = r_clr; n_k = r_k;
        n_r2 = r_r2; n_kill = r_kill; n_grow = r_grow; n_ov = r_ov; n_rsp = r_rsp;
        m_we = 1'b0; m_wd = 1'b0; m_a = {r_cx, r_cy};
        sq_start = 1'b0;
        if (r_ov && i_rsp_ready) n_ov = 1'b0;
        unique case (r_st)
            S_CLR: begin
                m_a = r_clr[AW-1:0];
                m_we = 1'b1;
                m_wd = (r_clr[AW-1:0] == AW'(HALF * GRID_SIZE + HALF));
                n_clr = r_clr + 1'b1;
                if (r_clr == (AW+1)'(CELLS - 1)) n_st = S_IDLE;
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_op = i_req.op; n_cos = i_req.cos_q; n_sin = i_req.sin_q;
                    n_stk = 1'b0;
                    if (i_req.op == OP_LAUNCH) begin
                        n_st = S_MUL;
                    end else if (!r_act) begin
                        n_st = S_OUT;
                    end else begin
                        unique case (i_req.dir)
                            DIR_PX: n_ox = (r_ox == 9'sd255) ? r_ox : r_ox + 9'sd1;
                            DIR_MX: n_ox = (r_ox == -9'sd256) ? r_ox : r_ox - 9'sd1;
                            DIR_PY: n_oy = (r_oy == 9'sd255) ? r_oy : r_oy + 9'sd1;
                            default: n_oy = (r_oy == -9'sd256) ? r_oy : r_oy - 9'sd1;
                        endcase
                        n_st = S_CELL;
                    end
                end
            end
            S_MUL: begin
                n_ox = sat9(w_px[33] ? -$signed({1'b0, w_mx[33:22]}) : $signed({1'b0, w_mx[33:22]}));
                n_oy = sat9(w_py[33] ? -$signed({1'b0, w_my[33:22]}) : $signed({1'b0, w_my[33:22]}));
                n_st = S_CELL;
            end
            S_CELL: begin
                if (w_in) begin
                    n_cx = w_nx; n_cy = w_ny;
                end
                n_st = S_SQ;
            end
            S_SQ: begin
                n_r2 = 34'(r_ox * r_ox) + 34'(r_oy * r_oy);
                n_k = 3'd0; n_nb = 1'b0;
                n_st = (r_op == OP_LAUNCH) ? S_ACT : S_RD;
                if (r_op == OP_STEP && !((r_cx > 0) && (r_cx < CW'(GRID_SIZE - 1)) &&
                    (r_cy > 0) && (r_cy < CW'(GRID_SIZE - 1)))) n_st = S_ACT;
            end
            S_RD: begin
                unique case (r_k[1:0])
                    2'd0: m_a = {r_cx + 1'b1, r_cy};
                    2'd1: m_a = {r_cx - 1'b1, r_cy};
                    2'd2: m_a = {r_cx, r_cy - 1'b1};
                    default: m_a = {r_cx, r_cy + 1'b1};
                endcase
                n_st = S_NB;
            end
            S_NB: begin
                n_nb = r_nb | m_rd;
                n_k = r_k + 3'd1;
                if (r_k == 3'd3) n_st = S_STK;
                else n_st = S_RD;
            end
            S_STK: begin
                if (r_nb) begin
                    m_we = 1'b1; m_wd = 1'b1;
                    n_stk = 1'b1;
                    if (r_pc != 15'h7FFF) n_pc = r_pc + 15'd1;
                    n_r2 = {r_r2[17:0], 16'd0};
                    n_grow = ({r_r2[17:0], 16'd0} > 34'({18'd0, r_rm} * {18'd0, r_rm}));
                    n_st = S_SQRT;
                end else begin
                    n_st = S_ACT;
                end
            end
            S_SQRT: begin
                if (!r_grow) begin
                    n_st = S_ACT;
                end else if (!r_kill) begin
                    sq_start = 1'b1;
                    n_kill = 1'b1;
                end else if (sq_done) begin
                    n_rm = sq_root[16] ? 16'hFFFF : sq_root[15:0];
                    n_kill = 1'b0;
                    n_st = S_ACT;
                end
            end
            S_ACT: begin
                n_r2 = 34'(r_ox * r_ox) + 34'(r_oy * r_oy);
                n_st = S_OWN;
            end
            S_OWN: begin
                n_act = ({r_r2, 16'd0} < {14'd0, w_kr2}) && !m_rd;
                n_st = S_OUT;
            end
            default: begin
                if (!r_ov || i_rsp_ready) begin
                    n_ov = 1'b1;
                    n_rsp.pos_x = 7'(r_cx);
                    n_rsp.pos_y = 7'(r_cy);
                    n_rsp.stuck = r_stk;
                    n_rsp.walking = (r_op == OP_STEP && !r_act && !r_stk && n_act == r_act) ? r_act : r_act;
                    n_rsp.particles = r_pc;
                    n_rsp.radius_q = r_rm;
                    n_rsp.done_res = (r_rm >= 16'(HALF * 256));
                    n_st = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR; r_clr <= '0; r_lm <= 6'd5; r_km <= 7'd50;
            r_ox <= '0; r_oy <= '0; r_cx <= '0; r_cy <= '0; r_rm <= '0; r_pc <= '0;
            r_act <= 1'b0; r_ov <= 1'b0; r_kill <= 1'b0;
        end else begin
            r_st <= n_st; r_clr <= n_clr;
            r_ox <= n_ox; r_oy <= n_oy; r_cx <= n_cx; r_cy <= n_cy;
            r_rm <= n_rm; r_pc <= n_pc; r_act <= n_act; r_ov <= n_ov; r_kill <= n_kill;
            if (psel && penable && pwrite) begin
                if (paddr[2] == REG_LAUNCH) r_lm <= pwdata[5:0];
                else r_km <= pwdata[6:0];
            end
        end
        r_stk <= n_stk; r_nb <= n_nb; r_op <= n_op; r_cos <= n_cos; r_sin <= n_sin;
        r_k <= n_k; r_r2 <= n_r2; r_grow <= n_grow; r_rsp <= n_rsp;
    end
endmodule

FILE: test/lattice_aggregation_walker_core_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lattice_aggregation_walker_core_chk
// Watches the request, response and APB channels of the walker core, keeps
// its own copy of the occupancy grid and walker state, predicts one response
// per accepted request and compares it with the actual response, in order.
// ----------------------------------------------------------------------------
module lattice_aggregation_walker_core_chk
    import law_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  t_req        i_req,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  t_rsp        i_rsp,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_errors,
    output int          o_pending
);

    bit          grid [CELLS];
    int          off_x, off_y;
    logic [6:0]  pos_x, pos_y;
    logic [15:0] rad_q;
    logic [14:0] count;
    bit          walking;
    logic [5:0]  launch_m;
    logic [6:0]  kill_m;
    t_rsp        awaited [$];

    function automatic int clamp9(longint v);
        if (v < -256) return -256;
        if (v > 255) return 255;
        return int'(v);
    endfunction

    function automatic int grid_idx(int cx, int cy);
        return (cx * GRID_SIZE + cy) % CELLS;
    endfunction

    function automatic longint root_floor(longint n);
        longint root, bitv;
        root = 0;
        bitv = longint'(1) << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic int launch_pos(longint rn, logic signed [15:0] c);
        longint p, m;
        p = rn * longint'(c);
        m = (p < 0) ? -p : p;
        m = m >> 22;
        return clamp9((p < 0) ? -m : m);
    endfunction

    function automatic longint dist_sq();
        return longint'(off_x) * off_x + longint'(off_y) * off_y;
    endfunction

    function automatic void snap_cell();
        if (off_x > -HALF && off_x < HALF - 1 && off_y > -HALF && off_y < HALF - 1) begin
            pos_x = 7'(off_x + HALF);
            pos_y = 7'(off_y + HALF);
        end
    endfunction

    function automatic void judge_walking();
        longint lim;
        lim = longint'(rad_q) + (longint'(kill_m) << 8);
        walking = ((dist_sq() << 16) < lim * lim) && !grid[grid_idx(pos_x, pos_y)];
    endfunction

    function automatic bit attach();
        int     x, y;
        longint r2s, q;
        x = pos_x;
        y = pos_y;
        if (!(x > 0 && x < GRID_SIZE - 1 && y > 0 && y < GRID_SIZE - 1)) return 0;
        if (!(grid[grid_idx(x + 1, y)] || grid[grid_idx(x - 1, y)] ||
              grid[grid_idx(x, y - 1)] || grid[grid_idx(x, y + 1)])) return 0;
        grid[grid_idx(x, y)] = 1;
        r2s = dist_sq() << 16;
        if (r2s > longint'(rad_q) * rad_q) begin
            q = root_floor(r2s);
            rad_q = (q > 65535) ? 16'hFFFF : 16'(q);
        end
        if (count < 15'h7FFF) count = count + 15'd1;
        return 1;
    endfunction

    function automatic t_rsp walk_item(t_req r);
        t_rsp   res;
        bit     stk;
        longint rn;
        stk = 0;
        if (r.op == OP_LAUNCH) begin
            rn = longint'(rad_q) + (longint'(launch_m) << 8);
            off_x = launch_pos(rn, r.cos_q);
            off_y = launch_pos(rn, r.sin_q);
            snap_cell();
            judge_walking();
        end else if (walking) begin
            case (r.dir)
                DIR_PX: off_x = clamp9(longint'(off_x) + 1);
                DIR_MX: off_x = clamp9(longint'(off_x) - 1);
                DIR_PY: off_y = clamp9(longint'(off_y) + 1);
                default: off_y = clamp9(longint'(off_y) - 1);
            endcase
            snap_cell();
            stk = attach();
            judge_walking();
        end
        res.pos_x     = pos_x;
        res.pos_y     = pos_y;
        res.stuck     = stk;
        res.walking   = walking;
        res.particles = count;
        res.radius_q  = rad_q;
        res.done_res  = (rad_q >= 16'(HALF << 8));
        return res;
    endfunction

    assign o_pending = awaited.size();

    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (!i_rst_n) begin
            foreach (grid[k]) grid[k] = 0;
            grid[grid_idx(HALF, HALF)] = 1;
            off_x    = 0;
            off_y    = 0;
            pos_x    = '0;
            pos_y    = '0;
            rad_q    = '0;
            count    = '0;
            walking  = 0;
            launch_m = 6'd5;
            kill_m   = 7'd50;
            awaited.delete();
            o_errors = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_LAUNCH) launch_m = i_pwdata[5:0];
                else kill_m = i_pwdata[6:0];
            end
            if (i_req_valid && i_req_ready) awaited.push_back(walk_item(i_req));
            if (i_rsp_valid && i_rsp_ready) begin
                if (awaited.size() == 0) begin
                    $display("%0t: unexpected response %p", $time, i_rsp);
                    o_errors = o_errors + 1;
                end else begin
                    exp_rsp = awaited.pop_front();
                    if (exp_rsp != i_rsp) begin
                        $display("%0t: response mismatch expected %p actual %p",
                                 $time, exp_rsp, i_rsp);
                        o_errors = o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: test/lattice_aggregation_walker_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lattice_aggregation_walker_core_tb
// Drives launch and step requests into the walker core under random
// handshake gaps and margin settings; the checker predicts every response.
// ----------------------------------------------------------------------------
module lattice_aggregation_walker_core_tb;
    import law_pkg::*;

    localparam int STALL_LIMIT = 60000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_req_valid;
    logic        o_req_ready;
    t_req        i_req;
    logic        o_rsp_valid;
    logic        i_rsp_ready;
    t_rsp        o_rsp;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          pending;
    bit          hold_rsp;
    bit          no_gaps;
    int          idle_cycles = 0;
    logic [6:0]  seen_x = 7'(HALF), seen_y = 7'(HALF);

    lattice_aggregation_walker_core dut (.*);

    lattice_aggregation_walker_core_chk chk (
        .i_clk, .i_rst_n, .i_req_valid, .i_req_ready(o_req_ready), .i_req,
        .i_rsp_valid(o_rsp_valid), .i_rsp_ready, .i_rsp(o_rsp),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (o_rsp_valid && i_rsp_ready) begin
            seen_x <= o_rsp.pos_x;
            seen_y <= o_rsp.pos_y;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int gap;
        i_rsp_ready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_rsp) begin
                i_rsp_ready = 0;
                repeat (400) @(negedge i_clk);
                hold_rsp = 0;
            end
            gap = no_gaps ? 0 : $urandom_range(0, 10);
            i_rsp_ready = 0;
            repeat (gap) @(negedge i_clk);
            i_rsp_ready = 1;
            do @(posedge i_clk); while (!(o_rsp_valid && i_rsp_ready));
        end
    end

    task automatic send(t_req r);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        repeat (gap) @(negedge i_clk);
        i_req_valid = 1;
        i_req       = r;
        do @(posedge i_clk); while (!o_req_ready);
        @(negedge i_clk);
        i_req_valid = 0;
    endtask

    task automatic launch_at(logic signed [15:0] c, logic signed [15:0] s);
        t_req r;
        r.op    = OP_LAUNCH;
        r.dir   = 2'($urandom_range(0, 3));
        r.cos_q = c;
        r.sin_q = s;
        send(r);
    endtask

    task automatic step_to(logic [1:0] d);
        t_req r;
        r.op    = OP_STEP;
        r.dir   = d;
        r.cos_q = 16'($urandom);
        r.sin_q = 16'($urandom);
        send(r);
    endtask

    task automatic set_margins(logic [5:0] lm, logic [6:0] km);
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        for (int k = 0; k < 2; k++) begin
            @(negedge i_clk);
            psel    = 1;
            penable = 0;
            pwrite  = 1;
            paddr   = (k == 0) ? {REG_LAUNCH, 2'b00} : {REG_KILL, 2'b00};
            pwdata  = (k == 0) ? {26'($urandom), lm} : {25'($urandom), km};
            @(negedge i_clk);
            penable = 1;
            do @(posedge i_clk); while (!pready);
            @(negedge i_clk);
            psel    = 0;
            penable = 0;
        end
    endtask

    function automatic logic [1:0] biased_dir();
        int dx, dy;
        dx = int'(seen_x) - HALF;
        dy = int'(seen_y) - HALF;
        if ($urandom_range(0, 9) < 4) return 2'($urandom_range(0, 3));
        if ((dx < 0 ? -dx : dx) >= (dy < 0 ? -dy : dy)) return (dx > 0) ? DIR_MX : DIR_PX;
        return (dy > 0) ? DIR_MY : DIR_PY;
    endfunction

    task automatic random_phase(int n);
        int  done_items, walk;
        real ang;
        done_items = 0;
        while (done_items < n) begin
            if ($urandom_range(0, 9) == 0) begin
                launch_at(16'($urandom), 16'($urandom));
            end else begin
                ang = $urandom_range(0, 3599) * 3.14159265 / 1800.0;
                launch_at(16'($rtoi(16384.0 * $cos(ang))), 16'($rtoi(16384.0 * $sin(ang))));
            end
            walk = $urandom_range(3, 40);
            for (int k = 0; k < walk; k++) step_to(biased_dir());
            done_items += walk + 1;
        end
    endtask

    initial begin
        i_rst_n     = 0;
        i_req_valid = 0;
        i_req       = '0;
        psel        = 0;
        penable     = 0;
        pwrite      = 0;
        paddr       = '0;
        pwdata      = '0;
        hold_rsp    = 0;
        no_gaps     = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1;

        // Steps before any launch do nothing; then axis, diagonal, extreme and zero launches under several margins.
        step_to(DIR_PX);
        launch_at(16'sd16384, 16'sd0);
        step_to(DIR_MX);
        step_to(DIR_MX);
        step_to(DIR_MX);
        step_to(DIR_MX);
        launch_at(-16'sd16384, 16'sd0);
        step_to(DIR_PX);
        step_to(DIR_PY);
        step_to(DIR_MY);
        step_to(DIR_PX);
        step_to(DIR_PX);
        step_to(DIR_PX);
        step_to(DIR_PX);
        launch_at(16'sh7FFF, -16'sh8000);
        launch_at(16'sd0, 16'sd0);
        set_margins(6'd63, 7'd127);
        launch_at(16'sd16384, 16'sd16384);
        launch_at(-16'sh8000, 16'sh7FFF);
        step_to(DIR_MY);
        set_margins(6'd0, 7'd0);
        launch_at(16'sd0, -16'sd16384);
        step_to(DIR_PY);
        set_margins(6'd1, 7'd3);
        launch_at(16'sd0, 16'sd16384);
        step_to(DIR_MY);

        hold_rsp = 1;
        random_phase(110);
        set_margins(6'd2, 7'd6);
        random_phase(120);
        no_gaps = 1;
        set_margins(6'd3, 7'd10);
        random_phase(120);
        no_gaps = 0;
        set_margins(6'd1, 7'd127);
        random_phase(100);
        set_margins(6'd63, 7'd127);
        random_phase(60);
        set_margins(6'd4, 7'd20);
        random_phase(120);
        set_margins(6'd0, 7'd8);
        random_phase(100);

        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
